[hw/rtl/assert_macros.svh]
// assertion helpers, clocked on clk_i and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VNA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VNA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define VNA_ASSERT(lbl, prop, msg)
`define VNA_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/vna_pkg.sv]
package vna_pkg;

  localparam int unsigned VERTEX_DEPTH_DEF = 1024;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned POS_W = 20;
  localparam int unsigned DIF_W = POS_W + 1;
  localparam int unsigned PRD_W = 2 * DIF_W;
  localparam int unsigned ACC_W = 26;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned VEC_W = PRD_W + 1;
  localparam int unsigned MAG_BITS = 30;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_LOAD, S_POS_A, S_POS_B, S_POS_C, S_POS_D,
    S_DIFF, S_CROSS, S_CHECK, S_RD_ACC, S_RD_GET, S_UNIT, S_ACC_RD, S_ACC_WR
  } top_state_e;

  typedef enum logic [2:0] {
    U_IDLE, U_SHIFT, U_SQ, U_SINIT, U_SQRT, U_DINIT, U_DIV, U_DONE
  } unit_state_e;

  typedef logic [2:0][ACC_W-1:0] acc_word_t;
  typedef logic [2:0][POS_W-1:0] pos_word_t;

  typedef struct packed {
    logic                  start;
    logic [2:0][VEC_W-1:0] c;
  } unit_req_t;

  typedef struct packed {
    logic                  done;
    logic [2:0][NRM_W-1:0] u;
  } unit_resp_t;

endpackage

[hw/rtl/vertex_normal_accumulator.sv]
// Smooth vertex normals. After reset the block clears its accumulator memory
// with busy_o high. A triangle or a read goes through the shared normalize
// unit unless the face is degenerate or the sum is zero: magnitude shift,
// three squares, a 32-step square root and three 15-step divisions. Results
// come out on done_o for a single cycle and cannot be stalled, so the receiver
// must take every word.
`include "assert_macros.svh"
module vertex_normal_accumulator #(
  parameter int unsigned VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       operation_i,
  input  logic [vna_pkg::IDX_W-1:0]        vertex_index_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_z_i,
  input  logic [vna_pkg::IDX_W-1:0]        corner_a_i,
  input  logic [vna_pkg::IDX_W-1:0]        corner_b_i,
  input  logic [vna_pkg::IDX_W-1:0]        corner_c_i,
  output logic                             done_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_z_o,
  output logic                             zero_normal_o
);
  import vna_pkg::*;

  localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam logic [16:0] DEPTH_L = 17'(VERTEX_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(VERTEX_DEPTH - 1);

  top_state_e state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [2:0]    cnt_q;
  logic [1:0]    j_q;
  logic          done_q;

  op_e                   op_q;
  logic [IDX_W-1:0]      vidx_q;
  pos_word_t             pin_q;
  logic [2:0][IDX_W-1:0] corner_q;

  pos_word_t pos_mem [VERTEX_DEPTH];
  acc_word_t acc_mem [VERTEX_DEPTH];
  pos_word_t pos_rd_q;
  acc_word_t acc_rd_q;

  pos_word_t                         pa_q, pb_q, pc_q;
  logic signed [2:0][DIF_W-1:0]      d0_q, d1_q;
  logic signed [PRD_W-1:0]           prod_q;
  logic [2:0][VEC_W-1:0]             n_q;
  logic [2:0][NRM_W-1:0]             res_q;

  logic          pos_we, acc_we;
  logic [AW-1:0] acc_waddr, acc_raddr, pos_raddr, vaddr;
  acc_word_t     acc_wdata, acc_sat;
  logic          vidx_ok, tri_ok, n_zero, acc_zero, res_set, res_zero;
  logic signed [DIF_W-1:0] mul_a, mul_b;
  unit_req_t     ureq;
  unit_resp_t    uresp;

  assign vaddr   = AW'(vidx_q);
  assign vidx_ok = 17'(vidx_q) < DEPTH_L;
  assign tri_ok  = (17'(corner_q[0]) < DEPTH_L) && (17'(corner_q[1]) < DEPTH_L) &&
                   (17'(corner_q[2]) < DEPTH_L);
  assign n_zero   = (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
  assign acc_zero = (acc_rd_q[0] == '0) && (acc_rd_q[1] == '0) && (acc_rd_q[2] == '0);

  // saturating add of the unit normal into one accumulator word
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [ACC_W:0] sum;
      sum = {acc_rd_q[k][ACC_W-1], acc_rd_q[k]} + (ACC_W+1)'($signed(uresp.u[k]));
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_sat[k] = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_sat[k] = sum[ACC_W-1:0];
      end
    end
  end

  // cross product operand order: n = d0 x d1, six products over the multiplier
  always_comb begin
    case (cnt_q)
      3'd0:    begin mul_a = d0_q[1]; mul_b = d1_q[2]; end
      3'd1:    begin mul_a = d0_q[2]; mul_b = d1_q[1]; end
      3'd2:    begin mul_a = d0_q[2]; mul_b = d1_q[0]; end
      3'd3:    begin mul_a = d0_q[0]; mul_b = d1_q[2]; end
      3'd4:    begin mul_a = d0_q[0]; mul_b = d1_q[1]; end
      default: begin mul_a = d0_q[1]; mul_b = d1_q[0]; end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ureq.c[k] = (op_q == OP_READ) ? VEC_W'($signed(acc_rd_q[k])) : n_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pos_we     = 1'b0;
    acc_we     = 1'b0;
    acc_waddr  = vaddr;
    acc_wdata  = '0;
    acc_raddr  = vaddr;
    pos_raddr  = AW'(corner_q[0]);
    ureq.start = 1'b0;
    res_set    = 1'b0;
    res_zero   = 1'b1;
    case (state_q)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_q;
        if (clr_q == CLR_LAST) state_d = S_IDLE;
      end
      S_IDLE: if (start_i) state_d = S_DECODE;
      S_DECODE: begin
        case (op_q)
          OP_LOAD: state_d = vidx_ok ? S_LOAD : S_IDLE;
          OP_TRI:  state_d = tri_ok ? S_POS_A : S_IDLE;
          OP_READ: begin
            state_d = vidx_ok ? S_RD_ACC : S_IDLE;
            res_set = !vidx_ok;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_LOAD: begin
        pos_we  = 1'b1;
        acc_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_POS_A: state_d = S_POS_B;
      S_POS_B: begin
        pos_raddr = AW'(corner_q[1]);
        state_d   = S_POS_C;
      end
      S_POS_C: begin
        pos_raddr = AW'(corner_q[2]);
        state_d   = S_POS_D;
      end
      S_POS_D: state_d = S_DIFF;
      S_DIFF:  state_d = S_CROSS;
      S_CROSS: if (cnt_q == 3'd6) state_d = S_CHECK;
      S_CHECK: begin
        ureq.start = !n_zero;
        state_d    = n_zero ? S_IDLE : S_UNIT;
      end
      S_RD_ACC: state_d = S_RD_GET;
      S_RD_GET: begin
        ureq.start = !acc_zero;
        res_set    = acc_zero;
        state_d    = acc_zero ? S_IDLE : S_UNIT;
      end
      S_UNIT: begin
        if (uresp.done) begin
          if (op_q == OP_READ) begin
            res_set  = 1'b1;
            res_zero = 1'b0;
            state_d  = S_IDLE;
          end else begin
            state_d = S_ACC_RD;
          end
        end
      end
      S_ACC_RD: begin
        acc_raddr = AW'(corner_q[j_q]);
        state_d   = S_ACC_WR;
      end
      S_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = AW'(corner_q[j_q]);
        acc_wdata = acc_sat;
        state_d   = (j_q == 2'd2) ? S_IDLE : S_ACC_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      cnt_q  <= '0;
      j_q    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= res_set;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == S_DIFF) cnt_q <= '0;
      if (state_q == S_CROSS) cnt_q <= cnt_q + 3'd1;
      if (state_q == S_DECODE) j_q <= '0;
      if (state_q == S_ACC_WR) j_q <= j_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q     <= op_e'(operation_i);
      vidx_q   <= vertex_index_i;
      pin_q    <= {pos_z_i, pos_y_i, pos_x_i};
      corner_q <= {corner_c_i, corner_b_i, corner_a_i};
    end
    if (state_q == S_POS_B) pa_q <= pos_rd_q;
    if (state_q == S_POS_C) pb_q <= pos_rd_q;
    if (state_q == S_POS_D) pc_q <= pos_rd_q;
    if (state_q == S_DIFF) begin
      for (int k = 0; k < 3; k++) begin
        d0_q[k] <= DIF_W'($signed(pb_q[k])) - DIF_W'($signed(pa_q[k]));
        d1_q[k] <= DIF_W'($signed(pc_q[k])) - DIF_W'($signed(pa_q[k]));
      end
    end
    if (state_q == S_CROSS) begin
      prod_q <= mul_a * mul_b;
      case (cnt_q)
        3'd1:    n_q[0] <= VEC_W'(prod_q);
        3'd2:    n_q[0] <= n_q[0] - VEC_W'(prod_q);
        3'd3:    n_q[1] <= VEC_W'(prod_q);
        3'd4:    n_q[1] <= n_q[1] - VEC_W'(prod_q);
        3'd5:    n_q[2] <= VEC_W'(prod_q);
        3'd6:    n_q[2] <= n_q[2] - VEC_W'(prod_q);
        default: ;
      endcase
    end
    if (res_set) res_q <= res_zero ? '0 : uresp.u;
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[vaddr] <= pin_q;
    pos_rd_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd_q <= acc_mem[acc_raddr];
  end

  vna_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .resp_o (uresp)
  );

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign normal_x_o    = res_q[0];
  assign normal_y_o    = res_q[1];
  assign normal_z_o    = res_q[2];
  assign zero_normal_o = (res_q[0] == '0) && (res_q[1] == '0) && (res_q[2] == '0);

  `VNA_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accepted word left block idle")
  `VNA_ASSERT(a_done_pulse, done_o |=> !done_o, "result strobe longer than one cycle")
  `VNA_NEVER(a_done_busy, done_o && busy_o, "result strobe while busy")
  `VNA_ASSERT(a_unit_start, ureq.start |=> (state_q == S_UNIT), "unit started outside wait")

endmodule

[hw/rtl/vna_unit.sv]
module vna_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vna_pkg::unit_req_t req_i,
  output vna_pkg::unit_resp_t resp_o
);
  import vna_pkg::*;

  localparam int unsigned SQ_W = 2 * MAG_BITS;
  localparam int unsigned S_W = SQ_W + 2;
  localparam int unsigned R_W = S_W + 1;
  localparam int unsigned L_W = MAG_BITS + 1;
  localparam int unsigned QB = NRM_W - 1;
  localparam int unsigned D_W = MAG_BITS + QB + 2;

  unit_state_e state_q, state_d;
  logic [4:0] cnt_q;
  logic [1:0] k_q;

  logic [2:0]            neg_q;
  logic [2:0][VEC_W-1:0] m_q;
  logic [SQ_W-1:0]       prod_q;
  logic [S_W-1:0]        s_q;
  logic [R_W-1:0]        v_q, r_q, bit_q;
  logic [D_W-1:0]        rem_q, dsh_q;
  logic [QB-1:0]         q_q;
  logic [2:0][NRM_W-1:0] u_q;

  logic            big;
  logic [R_W-1:0]  rb;
  logic [L_W-1:0]  len;
  logic [MAG_BITS-1:0] mk;
  logic            ge;
  logic [QB-1:0]   q_nxt;

  always_comb begin
    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      big = big | (|m_q[k][VEC_W-1:MAG_BITS]);
    end
    rb    = r_q + bit_q;
    len   = r_q[L_W-1:0];
    mk    = m_q[k_q][MAG_BITS-1:0];
    ge    = rem_q >= dsh_q;
    q_nxt = {q_q[QB-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE:  if (req_i.start) state_d = U_SHIFT;
      U_SHIFT: if (!big) state_d = U_SQ;
      U_SQ:    if (cnt_q == 5'd3) state_d = U_SINIT;
      U_SINIT: state_d = U_SQRT;
      U_SQRT:  if (bit_q[0]) state_d = U_DINIT;
      U_DINIT: state_d = U_DIV;
      U_DIV: begin
        if (cnt_q == 5'(QB - 1)) state_d = (k_q == 2'd2) ? U_DONE : U_DINIT;
      end
      U_DONE:  state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      case (state_q)
        U_SHIFT: cnt_q <= '0;
        U_SQ:    cnt_q <= cnt_q + 5'd1;
        U_SINIT: k_q <= '0;
        U_DINIT: cnt_q <= '0;
        U_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(QB - 1)) k_q <= k_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          for (int k = 0; k < 3; k++) begin
            neg_q[k] <= req_i.c[k][VEC_W-1];
            m_q[k]   <= req_i.c[k][VEC_W-1] ? VEC_W'(-$signed(req_i.c[k])) : req_i.c[k];
          end
        end
      end
      U_SHIFT: begin
        if (big) begin
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
        end
        s_q <= '0;
      end
      U_SQ: begin
        if (cnt_q < 5'd3) begin
          prod_q <= m_q[cnt_q[1:0]][MAG_BITS-1:0] * m_q[cnt_q[1:0]][MAG_BITS-1:0];
        end
        if (cnt_q != 5'd0) s_q <= s_q + S_W'(prod_q);
      end
      U_SINIT: begin
        v_q   <= R_W'(s_q);
        r_q   <= '0;
        bit_q <= R_W'(1) << (R_W - 1);
      end
      U_SQRT: begin
        if (v_q >= rb) begin
          v_q <= v_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      U_DINIT: begin
        rem_q <= D_W'({mk, QB'(0)}) + D_W'(len);
        dsh_q <= D_W'({len, QB'(0)});
        q_q   <= '0;
      end
      U_DIV: begin
        if (ge) rem_q <= rem_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        q_q   <= q_nxt;
        if (cnt_q == 5'(QB - 1)) begin
          u_q[k_q] <= neg_q[k_q] ? NRM_W'(-$signed({1'b0, q_nxt})) : NRM_W'({1'b0, q_nxt});
        end
      end
      default: ;
    endcase
  end

  assign resp_o.done = (state_q == U_DONE);
  assign resp_o.u    = u_q;

endmodule

[test/vertex_normal_accumulator_tb.sv]
module vertex_normal_accumulator_tb;
  import vna_pkg::*;

  typedef longint vec3_t[3];

  typedef struct {
    op_e                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] px, py, pz;
    logic [IDX_W-1:0]        ca, cb, cc;
    bit                      drain;
  } word_t;

  typedef struct {
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic                    zero;
  } normal_t;

  localparam int DEPTH = VERTEX_DEPTH_DEF;
  localparam int STALL_LIMIT = 6000;
  localparam longint ACC_HI = 33554431;
  localparam longint ACC_LO = -33554432;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic [1:0]              operation_i = '0;
  logic [IDX_W-1:0]        vertex_index_i = '0;
  logic signed [POS_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [IDX_W-1:0]        corner_a_i = '0, corner_b_i = '0, corner_c_i = '0;
  logic                    busy_o, done_o, zero_normal_o;
  logic signed [NRM_W-1:0] normal_x_o, normal_y_o, normal_z_o;

  vertex_normal_accumulator dut (.*);

  always #6 clk_i = ~clk_i;

  word_t   word_q[$];
  normal_t normal_q[$];
  word_t   cur;
  int      gap = 0;
  int      errors = 0;
  int      idle_cycles = 0;

  longint pos_mem[DEPTH][3];
  longint acc_mem[DEPTH][3];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vec3_t unit_vec(input vec3_t c);
    longint unsigned m[3], mx, s, len, q;
    vec3_t u;
    mx = 0;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = c[k] < 0 ? -c[k] : c[k];
      if (m[k] > mx) mx = m[k];
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) m[k] >>= 1;
    end
    for (int k = 0; k < 3; k++) s += m[k] * m[k];
    len = root_floor(s);
    for (int k = 0; k < 3; k++) begin
      q = (m[k] * 32768 + len) / (2 * len);
      u[k] = c[k] < 0 ? -longint'(q) : longint'(q);
    end
    return u;
  endfunction

  function automatic void apply_word(input word_t w);
    vec3_t d0, d1, n, u;
    int    cn[3];
    normal_t r;
    case (w.op)
      OP_LOAD: begin
        pos_mem[w.idx][0] = w.px;
        pos_mem[w.idx][1] = w.py;
        pos_mem[w.idx][2] = w.pz;
        for (int k = 0; k < 3; k++) acc_mem[w.idx][k] = 0;
      end
      OP_TRI: begin
        for (int k = 0; k < 3; k++) begin
          d0[k] = pos_mem[w.cb][k] - pos_mem[w.ca][k];
          d1[k] = pos_mem[w.cc][k] - pos_mem[w.ca][k];
        end
        n[0] = d0[1] * d1[2] - d0[2] * d1[1];
        n[1] = d0[2] * d1[0] - d0[0] * d1[2];
        n[2] = d0[0] * d1[1] - d0[1] * d1[0];
        if (n[0] != 0 || n[1] != 0 || n[2] != 0) begin
          u = unit_vec(n);
          cn[0] = w.ca;
          cn[1] = w.cb;
          cn[2] = w.cc;
          for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++) begin
              acc_mem[cn[j]][k] += u[k];
              if (acc_mem[cn[j]][k] > ACC_HI) acc_mem[cn[j]][k] = ACC_HI;
              if (acc_mem[cn[j]][k] < ACC_LO) acc_mem[cn[j]][k] = ACC_LO;
            end
        end
      end
      OP_READ: begin
        r = '{0, 0, 0, 1'b1};
        n[0] = acc_mem[w.idx][0];
        n[1] = acc_mem[w.idx][1];
        n[2] = acc_mem[w.idx][2];
        if (n[0] != 0 || n[1] != 0 || n[2] != 0) begin
          u = unit_vec(n);
          r = '{u[0][NRM_W-1:0], u[1][NRM_W-1:0], u[2][NRM_W-1:0], 1'b0};
        end
        normal_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic bit word_ready();
    return word_q.size() > 0 && !(word_q[0].drain && normal_q.size() > 0);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(20, 80);
  endfunction

  task automatic drive_next();
    cur = word_q.pop_front();
    start_i        <= 1'b1;
    operation_i    <= cur.op;
    vertex_index_i <= cur.idx;
    pos_x_i        <= cur.px;
    pos_y_i        <= cur.py;
    pos_z_i        <= cur.pz;
    corner_a_i     <= cur.ca;
    corner_b_i     <= cur.cb;
    corner_c_i     <= cur.cc;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        apply_word(cur);
        gap = pick_gap();
        if (gap == 0 && word_ready()) drive_next();
        else start_i <= 1'b0;
      end else if (!start_i) begin
        if (gap > 0) gap--;
        else if (word_ready()) drive_next();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni && done_o) begin
      if (normal_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        e = normal_q.pop_front();
        if (normal_x_o !== e.nx)
          report($sformatf("normal_x %0d, expected %0d", normal_x_o, e.nx));
        if (normal_y_o !== e.ny)
          report($sformatf("normal_y %0d, expected %0d", normal_y_o, e.ny));
        if (normal_z_o !== e.nz)
          report($sformatf("normal_z %0d, expected %0d", normal_z_o, e.nz));
        if (zero_normal_o !== e.zero)
          report($sformatf("zero_normal %0b, expected %0b", zero_normal_o, e.zero));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("vertex_normal_accumulator regression: fail");
      $finish;
    end
  end

  int loaded[$];
  int pool[32];

  function automatic word_t noise_word(input op_e op);
    word_t w;
    w.op = op;
    w.idx = IDX_W'($urandom);
    w.px = POS_W'($urandom);
    w.py = POS_W'($urandom);
    w.pz = POS_W'($urandom);
    w.ca = IDX_W'($urandom);
    w.cb = IDX_W'($urandom);
    w.cc = IDX_W'($urandom);
    w.drain = 1'b0;
    return w;
  endfunction

  function automatic void add_load(input int i, input int x, input int y, input int z);
    word_t w;
    w = noise_word(OP_LOAD);
    w.idx = IDX_W'(i);
    w.px = POS_W'(x);
    w.py = POS_W'(y);
    w.pz = POS_W'(z);
    word_q.push_back(w);
    loaded.push_back(i);
  endfunction

  function automatic void add_tri(input int a, input int b, input int c);
    word_t w;
    w = noise_word(OP_TRI);
    w.ca = IDX_W'(a);
    w.cb = IDX_W'(b);
    w.cc = IDX_W'(c);
    word_q.push_back(w);
  endfunction

  function automatic void add_read(input int i, input bit drain);
    word_t w;
    w = noise_word(OP_READ);
    w.idx = IDX_W'(i);
    w.drain = drain;
    word_q.push_back(w);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8191) - 4096;
      1: return $urandom_range(0, 262143) - 131072;
      default: return $signed(20'($urandom));
    endcase
  endfunction

  initial begin
    int a, b, c, i, sel;
    // directed words: extremes, degenerate faces, zero sums, ignored op
    add_read(500, 1'b0);
    add_load(0, -524288, -524288, -524288);
    add_load(1023, 524287, -524288, 0);
    add_load(512, -524288, 524287, 524287);
    add_tri(0, 1023, 512);
    add_read(0, 1'b0);
    add_read(1023, 1'b0);
    add_read(512, 1'b0);
    add_load(3, 1, 1, 1);
    add_load(4, 2, 2, 2);
    add_load(5, 3, 3, 3);
    add_tri(3, 4, 5);
    add_tri(3, 3, 4);
    add_read(3, 1'b0);
    add_load(6, 1, 0, 0);
    add_load(7, 0, 1, 0);
    add_tri(3, 6, 7);
    add_tri(6, 3, 7);
    add_read(3, 1'b0);
    word_q.push_back(noise_word(OP_NONE));
    add_load(0, 0, 0, 0);
    add_read(0, 1'b1);
    add_read(1023, 1'b0);

    for (int k = 0; k < 32; k++) pool[k] = $urandom_range(0, DEPTH - 1);
    for (int n = 0; n < 1330; n++) begin
      sel = $urandom_range(0, 99);
      if (loaded.size() < 3 || sel < 25) begin
        i = $urandom_range(0, 3) == 0 ? $urandom_range(0, DEPTH - 1) : pool[$urandom_range(0, 31)];
        add_load(i, rand_coord(), rand_coord(), rand_coord());
      end else if (sel < 72) begin
        a = loaded[$urandom_range(0, loaded.size() - 1)];
        b = loaded[$urandom_range(0, loaded.size() - 1)];
        c = loaded[$urandom_range(0, loaded.size() - 1)];
        add_tri(a, b, c);
      end else if (sel < 95) begin
        i = $urandom_range(0, 4) == 0 ? $urandom_range(0, DEPTH - 1) : pool[$urandom_range(0, 31)];
        add_read(i, n == 700);
      end else begin
        word_q.push_back(noise_word(OP_NONE));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (word_q.size() == 0 && !start_i && normal_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("vertex_normal_accumulator regression: pass");
    else $display("vertex_normal_accumulator regression: fail");
    $finish;
  end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/vna_pkg.sv
hw/rtl/vna_unit.sv
hw/rtl/vertex_normal_accumulator.sv
test/vertex_normal_accumulator_tb.sv
